// File: sv/charge_energy_integrator_macros.svh
// Assertion macros shared by the charge and energy integrator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHARGE_ENERGY_INTEGRATOR_MACROS_SVH
`define CHARGE_ENERGY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CEI_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CEI_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: sv/cei_pkg.sv
// Shared types and constants of the charge and energy integrator.
// No dependencies; used by cei_front, cei_accum and the top level.
package cei_pkg;

   localparam int CodeWidth  = 16;
   localparam int TimeWidth  = 32;
   localparam int TotalWidth = 64;
   localparam int SplitWidth = 63;
   // Signed code times unsigned elapsed time (made signed with one extra bit).
   localparam int ProdWidth  = CodeWidth + TimeWidth + 1;

   // Transaction opcodes on the request channel.
   localparam logic OPCODE_SAMPLE = 1'b0;
   localparam logic OPCODE_CLEAR  = 1'b1;

   // What the accumulator stage does with a queued transaction.
   typedef enum logic [1:0] {
      KIND_HOLD,
      KIND_SAMPLE,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [CodeWidth-1:0]    current;
      logic signed [CodeWidth-1:0]    power;
      logic        [TimeWidth-1:0]    elapsed;
   } item_type;

   // Input register contents handed from the front stage to the accumulators.
   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

endpackage

// File: sv/charge_energy_integrator.sv
// Top level of the charge and energy (coulomb) counter.
// Depends on cei_pkg, cei_front and cei_accum.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  opcode, current_code, power_code, time_ms
//   rsp       out         rsp_valid/rsp_stall  net_charge, net_energy, discharged/charged
//
// One transaction per clock cycle is accepted when the result side keeps up.
// A transaction passes through the input register, then the multiply and saturating
// add into the totals, which also serve as the result register.
// Reset clears the time base and all four totals; no clearing pass is needed.
// A stalled result holds the totals; one more transaction waits in the input
// register before req_stall rises.
module charge_energy_integrator (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_opcode,
   input  logic signed [cei_pkg::CodeWidth-1:0]     req_current_code,
   input  logic signed [cei_pkg::CodeWidth-1:0]     req_power_code,
   input  logic        [cei_pkg::TimeWidth-1:0]     req_time_ms,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cei_pkg::TotalWidth-1:0]    rsp_net_charge,
   output logic signed [cei_pkg::TotalWidth-1:0]    rsp_net_energy,
   output logic        [cei_pkg::SplitWidth-1:0]    rsp_discharged_charge,
   output logic        [cei_pkg::SplitWidth-1:0]    rsp_charged_charge
);

   cei_pkg::stage_type stage;
   logic               advance;

   // Input register and time base.
   cei_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_current_code (req_current_code),
      .req_power_code   (req_power_code),
      .req_time_ms      (req_time_ms),
      .advance          (advance),
      .stage            (stage)
   );

   // Products, saturating totals and result handshake.
   cei_accum u_accum (
      .clock                 (clock),
      .reset                 (reset),
      .stage                 (stage),
      .advance               (advance),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_net_charge        (rsp_net_charge),
      .rsp_net_energy        (rsp_net_energy),
      .rsp_discharged_charge (rsp_discharged_charge),
      .rsp_charged_charge    (rsp_charged_charge)
   );

endmodule

// File: sv/cei_front.sv
// Request stage: input register, time base and elapsed-time difference.
// Depends on cei_pkg and charge_energy_integrator_macros.svh.
`include "charge_energy_integrator_macros.svh"

module cei_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic signed [cei_pkg::CodeWidth-1:0]   req_current_code,
   input  logic signed [cei_pkg::CodeWidth-1:0]   req_power_code,
   input  logic        [cei_pkg::TimeWidth-1:0]   req_time_ms,
   input  logic                                   advance,
   output cei_pkg::stage_type                     stage
);

   logic                               valid_ff, valid_in;
   cei_pkg::item_type                  item_ff, item_in;
   logic [cei_pkg::TimeWidth-1:0]      prev_time_ff, prev_time_in;
   logic                               time_valid_ff, time_valid_in;
   logic                               accept;

   // The input register is free when empty or when it moves on this cycle.
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   // Classify the transaction and take the wrapping time difference.
   always_comb begin
      item_in.current = req_current_code;
      item_in.power   = req_power_code;
      item_in.elapsed = req_time_ms - prev_time_ff;
      priority if (req_opcode == cei_pkg::OPCODE_CLEAR) begin
         item_in.kind = cei_pkg::KIND_CLEAR;
      end else if (!time_valid_ff) begin
         item_in.kind = cei_pkg::KIND_HOLD;
      end else begin
         item_in.kind = cei_pkg::KIND_SAMPLE;
      end
   end

   // Every accepted transaction restarts the time base at its timestamp.
   always_comb begin
      valid_in      = accept | (valid_ff & ~advance);
      prev_time_in  = accept ? req_time_ms : prev_time_ff;
      time_valid_in = time_valid_ff | accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         prev_time_ff  <= '0;
         time_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         prev_time_ff  <= prev_time_in;
         time_valid_ff <= time_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

   `CEI_ASSERT_NEXT(a_time_base_set, clock, reset, accept, time_valid_ff && (prev_time_ff == $past(req_time_ms)), "time base not restarted by transaction")

endmodule

// File: sv/cei_accum.sv
// Accumulator stage: two products, saturating totals and the result register.
// Depends on cei_pkg and charge_energy_integrator_macros.svh.
`include "charge_energy_integrator_macros.svh"

module cei_accum (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cei_pkg::stage_type                       stage,
   output logic                                     advance,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cei_pkg::TotalWidth-1:0]    rsp_net_charge,
   output logic signed [cei_pkg::TotalWidth-1:0]    rsp_net_energy,
   output logic        [cei_pkg::SplitWidth-1:0]    rsp_discharged_charge,
   output logic        [cei_pkg::SplitWidth-1:0]    rsp_charged_charge
);

   localparam int TW = cei_pkg::TotalWidth;
   localparam int SW = cei_pkg::SplitWidth;
   localparam int PW = cei_pkg::ProdWidth;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]         net_charge_ff, net_charge_in;
   logic [TW-1:0]         net_energy_ff, net_energy_in;
   logic [SW-1:0]         discharge_ff, discharge_in;
   logic [SW-1:0]         charge_ff, charge_in;
   logic signed [PW-1:0]  charge_prod;
   logic signed [PW-1:0]  energy_prod;
   logic [PW-1:0]         charge_neg;

   // Signed add of a product to a 64-bit total, clamped to the signed limits.
   function automatic logic [TW-1:0] sat_add_signed(input logic [TW-1:0] acc,
                                                    input logic [PW-1:0] d);
      logic [TW:0] s;
      s = {acc[TW-1], acc} + {{(TW-PW+1){d[PW-1]}}, d};
      if (s[TW] != s[TW-1]) begin
         return s[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
      end
      return s[TW-1:0];
   endfunction

   // Unsigned add of a magnitude to a 63-bit total, clamped to all ones.
   function automatic logic [SW-1:0] sat_add_unsigned(input logic [SW-1:0] acc,
                                                      input logic [PW-2:0] d);
      logic [SW:0] s;
      s = {1'b0, acc} + {{(SW-PW+2){1'b0}}, d};
      if (s[SW]) begin
         return {SW{1'b1}};
      end
      return s[SW-1:0];
   endfunction

   // The result register is free when empty or when it is taken this cycle.
   assign advance = stage.valid & (~rsp_valid_ff | ~rsp_stall);

   // Code times elapsed milliseconds, elapsed time taken as unsigned.
   assign charge_prod = stage.item.current * $signed({1'b0, stage.item.elapsed});
   assign energy_prod = stage.item.power * $signed({1'b0, stage.item.elapsed});
   assign charge_neg  = '0 - charge_prod;

   // Next totals for the transaction in the input register.
   always_comb begin
      net_charge_in = net_charge_ff;
      net_energy_in = net_energy_ff;
      discharge_in  = discharge_ff;
      charge_in     = charge_ff;
      if (advance) begin
         unique case (stage.item.kind)
            cei_pkg::KIND_CLEAR: begin
               net_charge_in = '0;
               net_energy_in = '0;
               discharge_in  = '0;
               charge_in     = '0;
            end
            cei_pkg::KIND_SAMPLE: begin
               net_charge_in = sat_add_signed(net_charge_ff, charge_prod);
               net_energy_in = sat_add_signed(net_energy_ff, energy_prod);
               if (charge_prod[PW-1]) begin
                  charge_in = sat_add_unsigned(charge_ff, charge_neg[PW-2:0]);
               end else begin
                  discharge_in = sat_add_unsigned(discharge_ff, charge_prod[PW-2:0]);
               end
            end
            default: begin
               // First sample: totals are reported unchanged.
            end
         endcase
      end
   end

   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         net_charge_ff <= '0;
         net_energy_ff <= '0;
         discharge_ff  <= '0;
         charge_ff     <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         net_charge_ff <= net_charge_in;
         net_energy_ff <= net_energy_in;
         discharge_ff  <= discharge_in;
         charge_ff     <= charge_in;
      end
   end

   // The totals themselves form the result register.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_net_charge        = $signed(net_charge_ff);
   assign rsp_net_energy        = $signed(net_energy_ff);
   assign rsp_discharged_charge = discharge_ff;
   assign rsp_charged_charge    = charge_ff;

   `CEI_ASSERT_NEXT(a_clear_zeroes, clock, reset, advance && (stage.item.kind == cei_pkg::KIND_CLEAR), (net_charge_ff == '0) && (net_energy_ff == '0) && (discharge_ff == '0) && (charge_ff == '0), "clear left a nonzero total")
   `CEI_ASSERT_NEXT(a_hold_keeps, clock, reset, advance && (stage.item.kind == cei_pkg::KIND_HOLD), $stable(net_charge_ff) && $stable(net_energy_ff) && $stable(discharge_ff) && $stable(charge_ff), "first sample changed a total")
   `CEI_ASSERT_NEXT(a_split_grows, clock, reset, advance && (stage.item.kind == cei_pkg::KIND_SAMPLE), (discharge_ff >= $past(discharge_ff)) && (charge_ff >= $past(charge_ff)), "split total decreased on a sample")

endmodule
